// ===== sv/page_bitmap_allocator_core_assert.svh =====
// assertion macros shared by the allocator rtl
// both expect clk and rst in scope
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pba_pkg.sv =====
`timescale 1ns / 1ps

package pba_pkg;

  // field widths
  localparam int PG_W   = 13;
  localparam int BYTE_W = PG_W - 3;
  localparam int FIRST_W = 12;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;

  localparam int MAX_PAGES_DEF = 4096;
  localparam logic [PG_W-1:0] TOTAL_RESET = PG_W'(4096);

  typedef logic [PG_W-1:0]   page_t;
  typedef logic [BYTE_W-1:0] byte_idx_t;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_OOM        = 2'd1;
  localparam logic [ST_W-1:0] ST_TAKEN      = 2'd2;
  localparam logic [ST_W-1:0] ST_FREE_AGAIN = 2'd3;

  // what the byte unit does with one map byte
  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_SET,
    MODE_RESERVE,
    MODE_CLEAR
  } bop_mode_t;

  typedef struct packed {
    byte_idx_t byte_idx;
    logic [7:0] data;
    bop_mode_t mode;
    page_t lo;
    page_t hi;
    page_t streak;
    page_t need;
  } bop_req_t;

  typedef struct packed {
    logic [7:0] data_new;
    page_t streak;
    logic found;
    page_t found_page;
    logic hit_taken;
    logic hit_free;
    logic [3:0] set_cnt;
    logic [3:0] clr_cnt;
  } bop_rsp_t;

endpackage

// ===== sv/pba_map_ram.sv =====
`timescale 1ns / 1ps

module pba_map_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/pba_byte_op.sv =====
`timescale 1ns / 1ps

module pba_byte_op (
  input  pba_pkg::bop_req_t req,
  output pba_pkg::bop_rsp_t rsp
);

  import pba_pkg::*;

  // walk the eight pages of one map byte, lowest page first
  always_comb begin
    page_t p;
    page_t streak;
    logic stop;
    rsp = '0;
    rsp.data_new = req.data;
    streak = req.streak;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      p = {req.byte_idx, 3'(b)};
      if (p >= req.lo && p < req.hi) begin
        case (req.mode)
          MODE_SEARCH: begin
            if (!rsp.found) begin
              if (req.data[b]) begin
                streak = '0;
              end else begin
                streak = streak + 1'b1;
                if (streak == req.need) begin
                  rsp.found = 1'b1;
                  rsp.found_page = p;
                end
              end
            end
          end
          MODE_SET: begin
            if (!req.data[b]) begin
              rsp.data_new[b] = 1'b1;
              rsp.set_cnt = rsp.set_cnt + 4'd1;
            end
          end
          MODE_RESERVE: begin
            if (!stop) begin
              if (req.data[b]) begin
                stop = 1'b1;
                rsp.hit_taken = 1'b1;
              end else begin
                rsp.data_new[b] = 1'b1;
                rsp.set_cnt = rsp.set_cnt + 4'd1;
              end
            end
          end
          default: begin
            // clear
            if (req.data[b]) begin
              rsp.clr_cnt = rsp.clr_cnt + 4'd1;
            end else begin
              rsp.hit_free = 1'b1;
            end
            rsp.data_new[b] = 1'b0;
          end
        endcase
      end
    end
    rsp.streak = streak;
  end

endmodule

// ===== sv/page_bitmap_allocator_core.sv =====
// sequence: free and reserve load the first map byte and then mark each byte touched;
// allocate loads, scans bytes onward from the hint, then loads again and marks each
// byte of the run found; command 3 and empty runs go straight to the result
// throughput: one transaction at a time, one map byte per cycle through the
// single read port of the map memory; a result may wait while the next is taken
// reset: synchronous clear pass writes (MAX_PAGES+7)/8 map bytes, 512 by default
`timescale 1ns / 1ps

`include "page_bitmap_allocator_core_assert.svh"

module page_bitmap_allocator_core #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [pba_pkg::PG_W-1:0]   total_pages,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pba_pkg::CMD_W-1:0]  command,
  input  logic [pba_pkg::FIRST_W-1:0] first_page,
  input  logic [pba_pkg::PG_W-1:0]   page_amount,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pba_pkg::FIRST_W-1:0] alloc_page,
  output logic [pba_pkg::ST_W-1:0]   status,
  output logic [pba_pkg::PG_W-1:0]   taken_count
);

  import pba_pkg::*;

  localparam int MAP_BYTES = (MAX_PAGES + 7) / 8;
  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_MARK,
    S_DONE
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] clr_addr;
  page_t page_total;
  page_t hint;
  page_t taken;
  page_t need;
  page_t streak;
  page_t lo_page;
  page_t hi_page;
  byte_idx_t cur_byte;
  byte_idx_t last_byte;
  bop_mode_t mode;
  logic [FIRST_W-1:0] res_page;
  logic [ST_W-1:0] res_status;

  page_t limit_now;
  page_t lim_m1;
  page_t first_ext;
  logic [PG_W:0] end_page;
  page_t hi_now;
  page_t hi_m1;
  page_t start_page;

  logic ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0] ram_wr_data;
  logic ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0] ram_rd_data;

  bop_req_t bop_req;
  bop_rsp_t bop_rsp;

  // command setup arithmetic, run end kept one bit wider so it cannot wrap
  always_comb begin
    limit_now = (32'(page_total) > MAX_PAGES) ? PG_W'(MAX_PAGES) : page_total;
    lim_m1 = limit_now - 1'b1;
    first_ext = {1'b0, first_page};
    end_page = {1'b0, first_ext} + {1'b0, page_amount};
    hi_now = (end_page < {1'b0, limit_now}) ? end_page[PG_W-1:0] : limit_now;
    hi_m1 = hi_now - 1'b1;
    start_page = bop_rsp.found_page + 1'b1 - need;
  end

  // byte unit request
  always_comb begin
    bop_req.byte_idx = cur_byte;
    bop_req.data = ram_rd_data;
    bop_req.mode = mode;
    bop_req.lo = lo_page;
    bop_req.hi = hi_page;
    bop_req.streak = streak;
    bop_req.need = need;
  end

  pba_byte_op u_byte_op (
    .req (bop_req),
    .rsp (bop_rsp)
  );

  // map memory ports
  always_comb begin
    in_stall = (state != S_IDLE);
    ram_rd_en = 1'b0;
    ram_rd_addr = ADDR_W'(cur_byte);
    ram_wr_en = 1'b0;
    ram_wr_addr = ADDR_W'(cur_byte);
    ram_wr_data = bop_rsp.data_new;
    unique case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      S_LOAD: begin
        ram_rd_en = 1'b1;
      end
      S_SEARCH: begin
        ram_rd_en = (cur_byte != last_byte);
        ram_rd_addr = ADDR_W'(cur_byte + 1'b1);
      end
      S_MARK: begin
        ram_wr_en = 1'b1;
        ram_rd_en = (cur_byte != last_byte);
        ram_rd_addr = ADDR_W'(cur_byte + 1'b1);
      end
      default: begin
      end
    endcase
  end

  pba_map_ram #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer, allocator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      hint <= '0;
      taken <= '0;
      page_total <= TOTAL_RESET;
    end else begin
      if (cfg_write) begin
        page_total <= total_pages;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAP_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_page <= '0;
            res_status <= ST_OK;
            streak <= '0;
            unique case (command) inside
              CMD_ALLOC: begin
                need <= (page_amount == '0) ? PG_W'(1) : page_amount;
                mode <= MODE_SEARCH;
                lo_page <= hint;
                hi_page <= limit_now;
                cur_byte <= hint[PG_W-1:3];
                last_byte <= lim_m1[PG_W-1:3];
                if (hint >= limit_now) begin
                  res_status <= ST_OOM;
                  state <= S_DONE;
                end else begin
                  state <= S_LOAD;
                end
              end
              CMD_FREE, CMD_RESERVE: begin
                if (command == CMD_FREE && hint > first_ext) begin
                  hint <= first_ext;
                end
                mode <= (command == CMD_FREE) ? MODE_CLEAR : MODE_RESERVE;
                lo_page <= first_ext;
                hi_page <= hi_now;
                cur_byte <= first_ext[PG_W-1:3];
                last_byte <= hi_m1[PG_W-1:3];
                state <= (hi_now > first_ext) ? S_LOAD : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= (mode == MODE_SEARCH) ? S_SEARCH : S_MARK;
        end
        S_SEARCH: begin
          if (bop_rsp.found) begin
            // run found: go back and mark it
            hint <= bop_rsp.found_page;
            res_page <= start_page[FIRST_W-1:0];
            lo_page <= start_page;
            hi_page <= bop_rsp.found_page + 1'b1;
            cur_byte <= start_page[PG_W-1:3];
            last_byte <= bop_rsp.found_page[PG_W-1:3];
            mode <= MODE_SET;
            state <= S_LOAD;
          end else if (cur_byte == last_byte) begin
            res_status <= ST_OOM;
            state <= S_DONE;
          end else begin
            streak <= bop_rsp.streak;
            cur_byte <= cur_byte + 1'b1;
          end
        end
        S_MARK: begin
          taken <= taken + PG_W'(bop_rsp.set_cnt) - PG_W'(bop_rsp.clr_cnt);
          if (bop_rsp.hit_free) begin
            res_status <= ST_FREE_AGAIN;
          end
          if (bop_rsp.hit_taken) begin
            res_status <= ST_TAKEN;
          end
          if (bop_rsp.hit_taken || cur_byte == last_byte) begin
            state <= S_DONE;
          end else begin
            cur_byte <= cur_byte + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            alloc_page <= res_page;
            status <= res_status;
            taken_count <= taken;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PBA_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state == S_DONE), "result without done")
  `PBA_ASSERT_IMP(a_no_write_idle, state == S_IDLE, !ram_wr_en, "map write while idle")
  `PBA_ASSERT_IMP(a_taken_bound, 1'b1, 32'(taken) <= MAX_PAGES, "taken count too large")
  `PBA_ASSERT_NXT(a_accept_start, in_valid && !in_stall, state == S_LOAD || state == S_DONE, "bad start")
  `PBA_ASSERT_IMP(a_byte_range, state == S_MARK || state == S_SEARCH, cur_byte <= last_byte, "walk overrun")

endmodule
